>>> design/tdpc_pkg.sv
`timescale 1ns / 1ps

package tdpc_pkg;

  typedef logic [1:0] state_t;

  localparam state_t ST_IDLE  = 2'd0;
  localparam state_t ST_DIV   = 2'd1;
  localparam state_t ST_CHECK = 2'd2;

  // first trial divisor
  localparam int FIRST_DIVISOR = 2;

endpackage

>>> design/trial_division_prime_check.sv
`timescale 1ns / 1ps

// Primality test by trial division. Pulse start with a number while busy is
// low; busy then stays high until the answer is ready, and done pulses for
// exactly one cycle with is_prime valid in that cycle. The receiver cannot
// stall: sample is_prime when done is high. Numbers 0 and 1 answer, not
// prime, in the cycle after start. For any other number, one shared restoring
// divider tries d = 2, 3, ... in turn; each trial runs WIDTH shift/subtract
// steps and then one check step. The search stops at the first exact divisor,
// or once d exceeds the quotient n / d. A prime n thus runs floor(sqrt(n))
// trials, and a composite with smallest factor p runs p - 1 trials. busy is
// already low in the cycle in which done is high, so the next number can be
// taken in that cycle.
module trial_division_prime_check #(
  parameter int WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] number,
  output logic             busy,
  output logic             done,
  output logic             is_prime
);

  localparam int CNT_W = $clog2(WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

  tdpc_pkg::state_t state;
  tdpc_pkg::state_t state_next;

  logic [WIDTH-1:0] num;
  logic [WIDTH-1:0] dvs;
  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] quo;
  logic [CNT_W-1:0] cnt;

  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;
  logic             fits;
  logic             accept;
  logic             below_two;

  assign busy      = (state != tdpc_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign below_two = (number < WIDTH'(tdpc_pkg::FIRST_DIVISOR));

  // one restoring step: bring down the next dividend bit, try to subtract
  assign trial = {rem, quo[WIDTH-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = !diff[WIDTH];

  always_comb begin
    state_next = state;
    case (state)
      tdpc_pkg::ST_IDLE: begin
        if (accept && !below_two) begin
          state_next = tdpc_pkg::ST_DIV;
        end
      end
      tdpc_pkg::ST_DIV: begin
        if (cnt == '0) begin
          state_next = tdpc_pkg::ST_CHECK;
        end
      end
      tdpc_pkg::ST_CHECK: begin
        if ((dvs > quo) || (rem == '0)) begin
          state_next = tdpc_pkg::ST_IDLE;
        end else begin
          state_next = tdpc_pkg::ST_DIV;
        end
      end
      default: begin
        state_next = tdpc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tdpc_pkg::ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= ((state == tdpc_pkg::ST_IDLE) && accept && below_two) ||
               ((state == tdpc_pkg::ST_CHECK) && ((dvs > quo) || (rem == '0)));
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      tdpc_pkg::ST_IDLE: begin
        if (accept) begin
          num      <= number;
          dvs      <= WIDTH'(tdpc_pkg::FIRST_DIVISOR);
          rem      <= '0;
          quo      <= number;
          cnt      <= CNT_LAST;
          is_prime <= 1'b0;
        end
      end
      tdpc_pkg::ST_DIV: begin
        rem <= fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
        quo <= {quo[WIDTH-2:0], fits};
        cnt <= cnt - 1'b1;
      end
      tdpc_pkg::ST_CHECK: begin
        // d > n/d means no divisor is left to try
        if (dvs > quo) begin
          is_prime <= 1'b1;
        end else if (rem == '0) begin
          is_prime <= 1'b0;
        end else begin
          dvs <= dvs + 1'b1;
          rem <= '0;
          quo <= num;
          cnt <= CNT_LAST;
        end
      end
      default: begin
        cnt <= CNT_LAST;
      end
    endcase
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  a_small_quick: assert property (@(posedge clk) disable iff (rst)
    (accept && below_two) |=> (done && !is_prime))
    else $error("0 or 1 not answered next cycle as not prime");

  a_divisor_min: assert property (@(posedge clk) disable iff (rst)
    busy |-> (dvs >= WIDTH'(tdpc_pkg::FIRST_DIVISOR)))
    else $error("trial divisor below two");

  a_finish_done: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> done)
    else $error("search ended without a result");

endmodule
